[design/bdar_pkg.sv]
// Shared types and constants for the button debounce and auto-repeat block.
// Depends on nothing; every other design file imports this package.
package bdar_pkg;

	// Width of the internal time arithmetic. Timestamps wrap at this width.
	localparam int TIME_BITS = 32;
	localparam int NOW_BITS = 32;
	localparam int MS_BITS = 16;
	localparam int NUM_BUTTONS = 3;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_BITS = 3 + NOW_BITS;
	localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * NUM_BUTTONS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// Configuration register map (word index, byte address = 4 * index).
	localparam int ADDR_BITS = 4;
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_REPEAT_DELAY = 2'd1;
	localparam logic [1:0] REG_REPEAT_PERIOD = 2'd2;
	localparam logic [1:0] REG_REPEAT_ENABLE = 2'd3;

	localparam logic [MS_BITS-1:0] DEBOUNCE_RESET = MS_BITS'(50);
	localparam logic [MS_BITS-1:0] REPEAT_DELAY_RESET = MS_BITS'(500);
	localparam logic [MS_BITS-1:0] REPEAT_PERIOD_RESET = MS_BITS'(100);

	typedef logic [TIME_BITS-1:0] time_val_t;

	typedef struct packed {
		logic [MS_BITS-1:0] debounce_ms;
		logic [MS_BITS-1:0] repeat_delay_ms;
		logic [MS_BITS-1:0] repeat_period_ms;
		logic               repeat_enable;
	} cfg_t;

	typedef struct packed {
		logic held;
		logic evt;
	} button_res_t;

	// Bring a millisecond timestamp to the internal time width.
	function automatic time_val_t to_time(input logic [NOW_BITS-1:0] now);
		return TIME_BITS'(now);
	endfunction

endpackage

[design/bdar_cfg.sv]
// APB-style configuration registers for the button debounce block.
// Depends on bdar_pkg for the register map and the cfg_t struct.
module bdar_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdar_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output bdar_pkg::cfg_t                cfg
);
	import bdar_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.repeat_delay_ms <= REPEAT_DELAY_RESET;
			cfg_q.repeat_period_ms <= REPEAT_PERIOD_RESET;
			cfg_q.repeat_enable <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ms <= pwdata[MS_BITS-1:0];
				REG_REPEAT_DELAY: cfg_q.repeat_delay_ms <= pwdata[MS_BITS-1:0];
				REG_REPEAT_PERIOD: cfg_q.repeat_period_ms <= pwdata[MS_BITS-1:0];
				REG_REPEAT_ENABLE: cfg_q.repeat_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_DEBOUNCE: prdata = 32'(cfg_q.debounce_ms);
			REG_REPEAT_DELAY: prdata = 32'(cfg_q.repeat_delay_ms);
			REG_REPEAT_PERIOD: prdata = 32'(cfg_q.repeat_period_ms);
			REG_REPEAT_ENABLE: prdata = 32'(cfg_q.repeat_enable);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[design/bdar_button.sv]
// Debounce and auto-repeat logic with the state of one button.
// Depends on bdar_pkg for the time type, cfg_t and button_res_t.
module bdar_button (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd,
	input  logic                   raw,
	input  bdar_pkg::time_val_t    now,
	input  bdar_pkg::cfg_t         cfg,
	output bdar_pkg::button_res_t  res
);
	import bdar_pkg::*;

	logic      last_raw_q;
	time_val_t last_change_q;
	logic      debounced_q;
	time_val_t press_start_q;
	time_val_t last_repeat_q;
	logic      repeating_q;

	logic      changed;
	time_val_t change_time;
	logic      stable;
	logic      rise;
	logic      fall;
	logic      hold_rep;
	logic      first_due;
	logic      next_due;
	logic      evt;

	always_comb begin
		changed = raw != last_raw_q;
		change_time = changed ? now : last_change_q;
		// A level counts as settled once it has been unchanged longer than the debounce time.
		stable = TIME_BITS'(now - change_time) > TIME_BITS'(cfg.debounce_ms);
		rise = stable & raw & ~debounced_q;
		fall = stable & ~raw & debounced_q;
		hold_rep = stable & raw & debounced_q & cfg.repeat_enable;
		first_due = TIME_BITS'(now - press_start_q) > TIME_BITS'(cfg.repeat_delay_ms);
		next_due = TIME_BITS'(now - last_repeat_q) > TIME_BITS'(cfg.repeat_period_ms);
		evt = rise | (hold_rep & (repeating_q ? next_due : first_due));
		res.held = stable ? raw : debounced_q;
		res.evt = evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b0;
			last_change_q <= '0;
			debounced_q <= 1'b0;
			press_start_q <= '0;
			last_repeat_q <= '0;
			repeating_q <= 1'b0;
		end else if (upd) begin
			last_raw_q <= raw;
			last_change_q <= change_time;
			if (stable) begin
				debounced_q <= raw;
			end
			if (rise) begin
				press_start_q <= now;
				last_repeat_q <= now;
				repeating_q <= 1'b0;
			end else if (fall) begin
				repeating_q <= 1'b0;
			end else if (hold_rep && evt) begin
				repeating_q <= 1'b1;
				last_repeat_q <= now;
			end
		end
	end

endmodule

[design/button_debounce_auto_repeat.sv]
// Top level of the three-button debounce and auto-repeat block.
// Depends on bdar_pkg, bdar_cfg and bdar_button.

// Each input transfer is one poll of the up, down and enter buttons (pressed
// bits, already active high) with a free-running millisecond timestamp; each
// poll gives exactly one output transfer with the debounced state of every
// button and a one-poll event bit that marks a fresh press or an auto-repeat.
// A raw level is taken as the debounced state once it has stayed unchanged for
// more than debounce_ms; while a button is held and repeat_enable is set,
// further events follow after more than repeat_delay_ms and then each time
// more than repeat_period_ms has passed. All time differences wrap at the
// timestamp width, so the timestamp may roll over freely. The block takes one
// poll per clock cycle while the output does not stall: a poll waits in an
// input register, is evaluated combinationally against the per-button state
// (short subtract-and-compare logic only), and its result lands in an output
// register, from which it leaves on its output transfer. While a result waits,
// the input register still takes one more poll; after that the input side
// stalls until the output register is freed, and it keeps accepting in a cycle
// in which the waiting result leaves.
// Write the configuration registers only while no poll is in flight.
module button_debounce_auto_repeat (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Poll input.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// From bit 0: raw_up, raw_down, raw_enter, now_ms[31:0], zero padding.
	input  logic [bdar_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	// Result output.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// From bit 0: held_up, held_down, held_enter, event_up, event_down,
	// event_enter, zero padding.
	output logic [bdar_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	// Configuration port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [bdar_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import bdar_pkg::*;

	cfg_t cfg;

	// Input register.
	logic                     in_valid_s1;
	logic [NUM_BUTTONS-1:0]   raw_s1;
	logic [NOW_BITS-1:0]      now_s1;

	// Output register.
	logic                     out_valid_s2;
	logic [NUM_BUTTONS-1:0]   held_s2;
	logic [NUM_BUTTONS-1:0]   evt_s2;

	logic                     out_free;
	logic                     advance;
	logic                     in_take;
	time_val_t                now_t;
	button_res_t              res [NUM_BUTTONS];

	// The output register can take a new result when it is empty or its
	// current result leaves in this cycle.
	assign out_free = ~out_valid_s2 | m_tready;
	assign advance = in_valid_s1 & out_free;
	assign s_tready = ~in_valid_s1 | out_free;
	assign in_take = s_tvalid & s_tready;
	assign now_t = to_time(now_s1);

	bdar_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// One state slice per button; state moves only when the poll in the input
	// register is evaluated.
	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		bdar_button u_btn (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (advance),
			.raw    (raw_s1[b]),
			.now    (now_t),
			.cfg    (cfg),
			.res    (res[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			raw_s1 <= s_tdata[NUM_BUTTONS-1:0];
			now_s1 <= s_tdata[NUM_BUTTONS +: NOW_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				held_s2[i] <= res[i].held;
				evt_s2[i] <= res[i].evt;
			end
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata = OUT_TDATA_BITS'({evt_s2, held_s2});

endmodule

[bench/tb_button_debounce_auto_repeat.sv]
// Testbench for the three-button debounce and auto-repeat block.
// Depends on bdar_pkg and button_debounce_auto_repeat; it checks every poll
// result against a behavioral prediction of the debounce and repeat timers.
`timescale 1ns / 1ps

module tb_button_debounce_auto_repeat;
	import bdar_pkg::*;

	// Clock, reset and the block's ports. Every input starts at a known value.
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// From bit 0: raw_up, raw_down, raw_enter, now_ms[31:0], zero padding.
	logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	// From bit 0: held_up, held_down, held_enter, event_up, event_down,
	// event_enter, zero padding.
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_BITS-1:0]      paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;

	button_debounce_auto_repeat i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// Settings the prediction runs with. They follow every register write.
	logic [MS_BITS-1:0] cfg_debounce_ms = DEBOUNCE_RESET;
	logic [MS_BITS-1:0] cfg_delay_ms = REPEAT_DELAY_RESET;
	logic [MS_BITS-1:0] cfg_period_ms = REPEAT_PERIOD_RESET;
	logic               cfg_repeat_en = 1'b0;

	// Per-button timer state, index 0 is up, 1 is down, 2 is enter.
	logic [2:0]      raw_prev = '0;
	logic [2:0]      held_state = '0;
	logic [2:0]      repeat_active = '0;
	logic [31:0]     raw_change_ms [3] = '{default: '0};
	logic [31:0]     press_ms [3] = '{default: '0};
	logic [31:0]     repeat_ms [3] = '{default: '0};

	// Predicted status words (held bits low, event bits high) still waiting
	// for their output transfer, oldest first.
	logic [5:0]      pending_status [$];

	logic [31:0]     poll_time = '0;
	logic            src_idle_on = 1'b1;
	logic            sink_idle_on = 1'b1;
	int              failures = 0;
	int              polls_sent = 0;
	int              results_checked = 0;
	int              events_predicted = 0;
	int              settings_used = 1;

	// Works out the status word for one poll and advances the timer state.
	// A raw change restarts that button's debounce timer; the level is only
	// taken once the wrapped time since the last change exceeds the debounce
	// setting. A fresh debounced press fires an event and arms the repeat
	// timers, a release disarms them, and a steady hold with repeat enabled
	// fires first after the delay and then after every period.
	function automatic logic [5:0] predict_status(input logic [2:0] raw,
			input logic [31:0] now);
		logic [5:0]  status;
		logic [31:0] since;
		logic        was_held;
		status = '0;
		for (int b = 0; b < 3; b++) begin
			if (raw[b] != raw_prev[b]) begin
				raw_change_ms[b] = now;
				raw_prev[b] = raw[b];
			end
			since = now - raw_change_ms[b];
			if (since > {16'd0, cfg_debounce_ms}) begin
				was_held = held_state[b];
				held_state[b] = raw[b];
				if (raw[b] && !was_held) begin
					status[3+b] = 1'b1;
					press_ms[b] = now;
					repeat_ms[b] = now;
					repeat_active[b] = 1'b0;
				end else if (!raw[b] && was_held) begin
					repeat_active[b] = 1'b0;
				end else if (raw[b] && was_held && cfg_repeat_en) begin
					if (!repeat_active[b]) begin
						since = now - press_ms[b];
						if (since > {16'd0, cfg_delay_ms}) begin
							repeat_active[b] = 1'b1;
							repeat_ms[b] = now;
							status[3+b] = 1'b1;
						end
					end else begin
						since = now - repeat_ms[b];
						if (since > {16'd0, cfg_period_ms}) begin
							repeat_ms[b] = now;
							status[3+b] = 1'b1;
						end
					end
				end
			end
			status[b] = held_state[b];
		end
		return status;
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%t ERROR %s", $realtime, msg);
	endtask

	// Output side: the sink stalls at random, about twelve times in a hundred, while
	// sink idling is on. Reading m_tvalid and m_tready at the edge sees the
	// values the block itself sampled there.
	always @(posedge clk) begin
		m_tready <= !sink_idle_on || ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin : check_status
		logic [5:0] want;
		logic [5:0] got;
		logic [5:0] bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[5:0];
			if (pending_status.size() == 0) begin
				note_failure($sformatf("result transfer with no poll pending: %b", got));
			end else begin
				want = pending_status.pop_front();
				results_checked++;
				bad = '0;
				for (int f = 0; f < 6; f++)
					if (got[f] !== want[f])
						bad[f] = 1'b1;
				if (bad != 0)
					note_failure($sformatf(
						"result %0d: held exp %b got %b, event exp %b got %b",
						results_checked, want[2:0], got[2:0], want[5:3], got[5:3]));
			end
		end
	end

	// One poll transfer. The valid stays high into the next poll unless an
	// idle gap is drawn, so back-to-back polls keep the input side busy.
	task automatic send_poll(input logic [2:0] raw, input logic [31:0] now);
		logic [5:0] status;
		while (src_idle_on && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_BITS'({now, raw});
		do
			@(posedge clk);
		while (!s_tready);
		status = predict_status(raw, now);
		if (status[5:3] != 0)
			events_predicted++;
		pending_status.push_back(status);
		poll_time = now;
		polls_sent++;
	endtask

	task automatic poll_after(input logic [2:0] raw, input logic [31:0] step);
		send_poll(raw, poll_time + step);
	endtask

	// The sender holds off until every pending result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [1:0] idx, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_BITS'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reads a register back and compares only the bits it implements.
	task automatic check_reg(input logic [1:0] idx, input logic [15:0] want);
		logic [31:0] rd;
		logic [15:0] mask;
		mask = (idx == REG_REPEAT_ENABLE) ? 16'h0001 : 16'hFFFF;
		apb_read(idx, rd);
		if ((rd[15:0] & mask) !== (want & mask))
			note_failure($sformatf("register %0d reads %h, expected %h",
				idx, rd[15:0] & mask, want & mask));
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] value);
		apb_write(idx, {16'd0, value});
		case (idx)
			REG_DEBOUNCE: begin
				cfg_debounce_ms = value;
			end
			REG_REPEAT_DELAY: begin
				cfg_delay_ms = value;
			end
			REG_REPEAT_PERIOD: begin
				cfg_period_ms = value;
			end
			REG_REPEAT_ENABLE: begin
				cfg_repeat_en = value[0];
			end
			default: begin
			end
		endcase
		check_reg(idx, value);
	endtask

	// Registers only change while no poll is in flight.
	task automatic apply_settings(input logic [15:0] debounce, input logic [15:0] delay,
			input logic [15:0] period, input logic enable);
		drain_results();
		set_reg(REG_DEBOUNCE, debounce);
		set_reg(REG_REPEAT_DELAY, delay);
		set_reg(REG_REPEAT_PERIOD, period);
		set_reg(REG_REPEAT_ENABLE, {15'd0, enable});
		settings_used++;
	endtask

	// A realistic button action: a short burst of contact bounce with steps up to a
	// quarter of step_max, then a steady level held over several polls.
	task automatic bounce_and_hold(input int unsigned step_max);
		logic [2:0] target;
		target = 3'($urandom);
		repeat ($urandom_range(0, 3))
			poll_after(3'($urandom), $urandom_range(0, step_max / 4));
		repeat ($urandom_range(3, 12))
			poll_after(target, $urandom_range(0, step_max));
	endtask

	task automatic test_register_reset();
		check_reg(REG_DEBOUNCE, DEBOUNCE_RESET);
		check_reg(REG_REPEAT_DELAY, REPEAT_DELAY_RESET);
		check_reg(REG_REPEAT_PERIOD, REPEAT_PERIOD_RESET);
		check_reg(REG_REPEAT_ENABLE, 16'd0);
	endtask

	// Reset settings: 50 ms debounce, repeat off.
	task automatic test_debounce_edges();
		send_poll(3'b000, 32'd0);
		send_poll(3'b111, 32'd10);          // every button changes, not yet stable
		send_poll(3'b111, 32'd60);          // exactly the debounce time: still held off
		send_poll(3'b111, 32'd61);          // one past it: press on all three
		send_poll(3'b111, 32'd900);         // long hold with repeat off gives nothing
		send_poll(3'b010, 32'd910);         // up and enter let go, still bouncing
		send_poll(3'b010, 32'd961);         // their release is accepted
		send_poll(3'b000, 32'd1100);
		send_poll(3'b000, 32'd1200);        // down released
		// The debounce window straddles the timestamp rollover.
		send_poll(3'b000, 32'hFFFF_FFF0);
		send_poll(3'b001, 32'hFFFF_FFF8);
		send_poll(3'b001, 32'hFFFF_FFFF);
		send_poll(3'b001, 32'h0000_0031);   // 57 ms after the change: up pressed
	endtask

	// Reset delay and period with repeat switched on.
	task automatic test_repeat_timing();
		apply_settings(DEBOUNCE_RESET, REPEAT_DELAY_RESET, REPEAT_PERIOD_RESET, 1'b1);
		send_poll(3'b010, 32'd256);
		send_poll(3'b010, 32'd320);         // down pressed, up released
		send_poll(3'b010, 32'd820);         // held exactly the delay: no repeat yet
		send_poll(3'b010, 32'd821);         // first repeat
		send_poll(3'b010, 32'd921);         // exactly one period: nothing
		send_poll(3'b010, 32'd922);         // next repeat
	endtask

	// All three times at zero: any time that moves at all is enough.
	task automatic test_zero_settings();
		apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
		send_poll(3'b000, 32'd1000);
		send_poll(3'b111, 32'd1100);        // same poll as the change: not stable
		send_poll(3'b111, 32'd1101);        // press
		send_poll(3'b111, 32'd1102);        // first repeat
		send_poll(3'b111, 32'd1102);        // no time passed: no event
		send_poll(3'b111, 32'd1103);        // later repeat
	endtask

	task automatic test_bounce_and_hold();
		repeat (11) begin
			apply_settings(16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
				16'($urandom_range(0, 25)), 1'b1);
			repeat (2) bounce_and_hold(12);
		end
	endtask

	// Largest settings, with polls far apart so the timers still expire.
	task automatic test_full_scale_settings();
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		repeat (8) bounce_and_hold(40000);
	endtask

	task automatic test_repeat_disabled();
		apply_settings(16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)),
			16'($urandom_range(0, 10)), 1'b0);
		repeat (8) bounce_and_hold(12);
	endtask

	// A long stretch with both sides running flat out.
	task automatic test_no_idle();
		apply_settings(16'($urandom_range(0, 8)), 16'($urandom_range(0, 20)),
			16'($urandom_range(0, 8)), 1'b1);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		repeat (10) bounce_and_hold(6);
		drain_results();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// Unstructured polls: random levels, random settings of any size, and now
	// and then a timestamp anywhere in the 32-bit range.
	task automatic test_random_noise();
		repeat (4) begin
			apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
			poll_time = 32'hFFFF_FF00;
			repeat (25) begin
				if ($urandom_range(7) == 0)
					send_poll(3'($urandom), $urandom);
				else
					poll_after(3'($urandom), $urandom_range(0, 70000));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_debounce_edges();
		test_repeat_timing();
		test_zero_settings();
		test_bounce_and_hold();
		test_full_scale_settings();
		test_repeat_disabled();
		test_no_idle();
		test_random_noise();
		drain_results();
		$display("Sent %0d polls under %0d register settings; %0d results checked.",
			polls_sent, settings_used, results_checked);
		$display("Polls with a press or repeat event: %0d; timestamps crossed the rollover.",
			events_predicted);
		if (failures == 0 && pending_status.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
